@@ sv/rmsn_pkg.sv @@
// Shared types, constants and codes for the RMS normalization block.
package rmsn_pkg;

  localparam int unsigned VecLen      = 4096;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned LenWidth    = 13;
  localparam int unsigned SumWidth    = 44;
  localparam int unsigned InvWidth    = 24;
  localparam logic [SumWidth-1:0] EpsQ24 = 44'd168;

  localparam logic [1:0] StatusOk  = 2'd0;
  localparam logic [1:0] StatusSat = 2'd1;
  localparam logic [1:0] StatusEarly = 2'd2;

  localparam logic ActionLoad = 1'b0;
  localparam logic ActionEmit = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [SampleWidth-1:0] sample;
    logic signed [SampleWidth-1:0] gain;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] normalized;
    logic                          final_element;
    logic [1:0]                    status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // store sample, accumulate square
    logic restart;   // clear sum and count before this load
    logic div_start; // begin mean division
    logic sqrt_start;// begin 2^54 / (mean + eps) division then root
    logic read;      // read store entry for emit
    logic mul1;      // inverse_rms * |x|
    logic mul2;      // scaled * |g|
    logic finish;    // drive result
    logic early;     // drive early-emit error result
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic load_done; // count reached length after this load
    logic unit_done; // iterative unit finished
    logic last;      // current emit index is last
  } stat_t;

endpackage

@@ sv/rmsn_ctrl.sv @@
// Controller state machine: sequences load, inverse root and emit work.
module rmsn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               action_i,
  input  rmsn_pkg::stat_t    stat_i,
  output logic               busy_o,
  output rmsn_pkg::cmd_t     cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_RECIP = 10'b0000001000,
    S_ROOT  = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_MUL1  = 10'b0001000000,
    S_MUL2  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_EARLY = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   emitting_q, emitting_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    emitting_d = emitting_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i == rmsn_pkg::ActionLoad) begin
            cmd_o.load    = 1'b1;
            cmd_o.restart = emitting_q;
            emitting_d    = 1'b0;
            state_d       = S_LOAD;
          end else if (emitting_q) begin
            state_d = S_READ;
          end else begin
            state_d = S_EARLY;
          end
        end
      end
      S_LOAD: begin
        if (stat_i.load_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.unit_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_RECIP;
        end
      end
      S_RECIP: begin
        if (stat_i.unit_done) state_d = S_ROOT;
      end
      S_ROOT: begin
        if (stat_i.unit_done) begin
          emitting_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.finish = 1'b1;
        if (stat_i.last) emitting_d = 1'b0;
        state_d = S_IDLE;
      end
      S_EARLY: begin
        cmd_o.early = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      emitting_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      emitting_q <= emitting_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted word did not raise busy");
  a_emit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> emitting_q) else $error("emit read outside emit phase");

endmodule

@@ sv/rmsn_dp.sv @@
// Datapath: sample store, square accumulator, iterative divide and root, output math.
module rmsn_dp #(
  parameter int unsigned VEC_LEN = rmsn_pkg::VecLen
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     busy_i,
  input  logic signed [rmsn_pkg::SampleWidth-1:0]  sample_i,
  input  logic signed [rmsn_pkg::SampleWidth-1:0]  gain_i,
  input  logic [rmsn_pkg::LenWidth-1:0]            len_i,
  input  rmsn_pkg::cmd_t                           cmd_i,
  output rmsn_pkg::stat_t                          stat_o,
  output logic                                     valid_o,
  output logic signed [rmsn_pkg::SampleWidth-1:0]  normalized_o,
  output logic                                     final_o,
  output logic [1:0]                               status_o
);

  localparam int unsigned AW  = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int unsigned CW  = $clog2(VEC_LEN + 1) + 1;
  localparam int unsigned SW  = rmsn_pkg::SumWidth;
  localparam int unsigned IW  = rmsn_pkg::InvWidth;
  localparam int unsigned MW  = rmsn_pkg::SampleWidth;
  localparam int unsigned P1W = IW + MW;
  localparam int unsigned S1W = 33;
  localparam int unsigned P2W = S1W + MW;
  localparam int unsigned QW  = 55;

  logic [MW-1:0] mem_q [VEC_LEN];
  logic [MW-1:0] rd_q;
  logic [SW-1:0]  sum_q, sum_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  inv_q;
  logic [CW-1:0]  eff_len;
  logic [CW-1:0]  len_ext;

  // Clamp length to the range 1..VEC_LEN.
  assign len_ext = CW'(len_i);
  always_comb begin
    if (len_ext == '0) eff_len = CW'(1);
    else if (len_ext > CW'(VEC_LEN)) eff_len = CW'(VEC_LEN);
    else eff_len = len_ext;
  end

  // Square of incoming sample magnitude.
  logic [MW-1:0]    in_mag;
  logic [2*MW-1:0]  in_sq;
  logic [CW-1:0]    wr_cnt;
  assign in_mag = sample_i[MW-1] ? MW'(-sample_i) : MW'(sample_i);
  assign in_sq  = in_mag * in_mag;
  assign wr_cnt = (cmd_i.restart || cnt_q >= CW'(VEC_LEN)) ? '0 : cnt_q;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      sum_d = (cmd_i.restart ? '0 : sum_q) + SW'(in_sq);
      cnt_d = wr_cnt + CW'(1);
    end else if (cmd_i.div_start) begin
      cnt_d = '0;
    end else if (cmd_i.finish) begin
      if (stat_o.last) begin
        cnt_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  assign stat_o.load_done = (cnt_q >= eff_len);

  // Write store and read for emit.
  logic [CW-1:0] rd_idx;
  assign rd_idx = (cnt_q >= CW'(VEC_LEN)) ? CW'(VEC_LEN - 1) : cnt_q;
  assign stat_o.last = (rd_idx + CW'(1) >= eff_len);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem_q[wr_cnt[AW-1:0]] <= sample_i;
    if (cmd_i.read) rd_q <= mem_q[rd_idx[AW-1:0]];
  end

  // Hold the gain of the accepted word for the multiply stages.
  logic [MW-1:0] gain_q;
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) gain_q <= gain_i;
  end

  // Iterative restoring divider shared by both divisions, one bit per cycle.
  logic [QW-1:0] num_q, quo_q, den_q;
  logic [QW:0]   rem_q;
  logic [6:0]    dcnt_q;
  logic          dbusy_q, phase_q, rbusy_q;
  logic [QW:0]   rem_sh;
  assign rem_sh = {rem_q[QW-1:0], num_q[QW-1]};

  // Bitwise integer square root of quotient, two bits per step.
  logic [63:0] sq_q, res_q, bit_q;
  logic [5:0]  rcnt_q;

  logic        unit_done_q;
  assign stat_o.unit_done = unit_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      rbusy_q <= 1'b0;
      phase_q <= 1'b0;
      unit_done_q <= 1'b0;
      sum_q <= '0;
      cnt_q <= '0;
      inv_q <= '0;
      dcnt_q <= '0;
      rcnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      unit_done_q <= 1'b0;
      if (cmd_i.div_start) begin
        num_q <= QW'(sum_q);
        den_q <= QW'(eff_len);
        rem_q <= '0;
        quo_q <= '0;
        dcnt_q <= 7'(QW);
        dbusy_q <= 1'b1;
        phase_q <= 1'b0;
      end else if (cmd_i.sqrt_start) begin
        num_q <= QW'(64'd1 << 54);
        den_q <= QW'(quo_q) + QW'(rmsn_pkg::EpsQ24);
        rem_q <= '0;
        quo_q <= '0;
        dcnt_q <= 7'(QW);
        dbusy_q <= 1'b1;
        phase_q <= 1'b1;
      end else if (dbusy_q) begin
        num_q <= {num_q[QW-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) begin
          dbusy_q <= 1'b0;
          unit_done_q <= 1'b1;
          if (phase_q) begin
            rbusy_q <= 1'b1;
            sq_q <= '0;
            res_q <= '0;
            bit_q <= 64'd1 << 62;
            rcnt_q <= 6'd32;
          end
        end
      end else if (rbusy_q) begin
        if (rcnt_q == 6'd32) begin
          sq_q <= 64'(quo_q);
          rcnt_q <= 6'd31;
        end else begin
          if (sq_q >= res_q + bit_q) begin
            sq_q <= sq_q - (res_q + bit_q);
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            rbusy_q <= 1'b0;
            unit_done_q <= 1'b1;
            inv_q <= (res_q[63:IW] != '0 || (((res_q >> 1) + 64'd1) >> IW) != 0)
                     ? ((sq_q >= res_q + 64'd1) ? (((res_q >> 1) + 64'd1) > 64'hFFFFFF ?
                        {IW{1'b1}} : IW'((res_q >> 1) + 64'd1))
                        : (((res_q >> 1) > 64'hFFFFFF) ? {IW{1'b1}} : IW'(res_q >> 1)))
                     : ((sq_q >= res_q + 64'd1) ? IW'((res_q >> 1) + 64'd1)
                        : IW'(res_q >> 1));
          end
        end
      end
    end
  end

  // Output arithmetic: two registered multiplies.
  logic [MW-1:0]  x_mag, g_mag;
  logic           neg_x, neg_g;
  logic [P1W-1:0] p1;
  logic [S1W-1:0] s1_q;
  logic [P2W-1:0] p2_q;
  logic           sgn_q, sgn2_q;
  logic [MW-1:0]  gm_q;
  assign neg_x = rd_q[MW-1];
  assign neg_g = gain_q[MW-1];
  assign x_mag = neg_x ? MW'(-rd_q) : rd_q;
  assign g_mag = neg_g ? MW'(-gain_q) : gain_q;
  assign p1 = inv_q * x_mag;

  logic [P1W:0]   p1r;
  assign p1r = ({1'b0, p1} + (P1W+1)'(1 << 14)) >> 15;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      s1_q  <= (p1r > (P1W+1)'(64'd1 << 32)) ? S1W'(64'd1 << 32) : S1W'(p1r);
      sgn_q <= neg_x ^ neg_g;
      gm_q  <= g_mag;
    end
    if (cmd_i.mul2) begin
      p2_q   <= s1_q * gm_q;
      sgn2_q <= sgn_q;
    end
  end

  logic [P2W:0] mag;
  logic [P2W:0] maxpos;
  assign mag    = ({1'b0, p2_q} + (P2W+1)'(1 << 11)) >> 12;
  assign maxpos = (P2W+1)'((64'd1 << (MW - 1)) - 1);

  // Register the result word.
  logic                    v_q;
  logic [MW-1:0]           n_q;
  logic                    f_q;
  logic [1:0]              st_q;
  logic [P2W:0]            mclip;
  logic                    sat;
  always_comb begin
    sat = 1'b0;
    mclip = mag;
    if (sgn2_q) begin
      if (mag > maxpos + 1) begin mclip = maxpos + 1; sat = 1'b1; end
    end else if (mag > maxpos) begin
      mclip = maxpos; sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cmd_i.finish | cmd_i.early;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.early) begin
      n_q  <= '0;
      f_q  <= 1'b0;
      st_q <= rmsn_pkg::StatusEarly;
    end else if (cmd_i.finish) begin
      n_q  <= sgn2_q ? MW'(-mclip) : MW'(mclip);
      f_q  <= stat_o.last;
      st_q <= sat ? rmsn_pkg::StatusSat : rmsn_pkg::StatusOk;
    end
  end

  assign valid_o      = v_q;
  assign normalized_o = n_q;
  assign final_o      = f_q;
  assign status_o     = st_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.div_start, cmd_i.sqrt_start, cmd_i.read,
              cmd_i.mul1, cmd_i.mul2, cmd_i.finish, cmd_i.early}))
    else $error("more than one command");
  a_units: assert property (@(posedge clk_i) disable iff (!rst_ni) !(dbusy_q && rbusy_q))
    else $error("divider and root both busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(VEC_LEN))
    else $error("count beyond store");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> !valid_o) else $error("result too early");

endmodule

@@ sv/rms_normalize.sv @@
// Top level of the RMS normalization block.
// One vector at a time: load words store a sample; the word that completes
// the vector keeps busy high, once it is taken, through two bit-serial
// divisions (mean, then 2^54/(mean + eps)) and a square root, with a handoff
// after the load and after each unit. Emit words go through store read, two
// multiplies, round and output; the result strobe result_valid_o is high for
// exactly one cycle and cannot be stalled. An emit before loading completes
// returns status 2, as does an emit after the final element has been emitted.
// Write vector_length only while busy is low.
module rms_normalize #(
  parameter int unsigned VEC_LEN = rmsn_pkg::VecLen
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  rmsn_pkg::in_word_t                  in_word_i,
  output logic                                result_valid_o,
  output rmsn_pkg::out_word_t                 result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rmsn_pkg::LenWidth-1:0]       cfg_data_i
);

  rmsn_pkg::cmd_t  cmd;
  rmsn_pkg::stat_t stat;
  logic [rmsn_pkg::LenWidth-1:0] len_q;

  // Hold length register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= rmsn_pkg::LenWidth'(4096);
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  rmsn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start & ~busy),
    .action_i(in_word_i.action),
    .stat_i  (stat),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  rmsn_dp #(
    .VEC_LEN     (VEC_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .sample_i    (in_word_i.sample),
    .gain_i      (in_word_i.gain),
    .len_i       (len_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .valid_o     (result_valid_o),
    .normalized_o(result_o.normalized),
    .final_o     (result_o.final_element),
    .status_o    (result_o.status)
  );

endmodule
